FILE: hdl/cfd_pkg.sv
// Shared types, constants and the bytewise CRC function of the frame decoder.
package cfd_pkg;

  localparam int FRAME_BYTES = 19;
  localparam int CRC_SPAN    = 17;
  localparam int CHAIN_CELLS = FRAME_BYTES - 1;
  localparam int COUNT_W     = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEADER_WORD    = 3'd0,
    CFG_OFFER_CODE     = 3'd1,
    CFG_REPLY_CODE     = 3'd2,
    CFG_MAX_APPEARANCE = 3'd3,
    CFG_MAX_EVOLUTION  = 3'd4,
    CFG_MAX_BOND       = 3'd5,
    CFG_MAX_MOOD       = 3'd6,
    CFG_MAX_EMOTE      = 3'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_LENGTH  = 4'd1,
    ST_HEADER  = 4'd2,
    ST_VERSION = 4'd3,
    ST_TYPE    = 4'd4,
    ST_CRC     = 4'd5,
    ST_UID     = 4'd6,
    ST_PACK    = 4'd7,
    ST_APPEAR  = 4'd8,
    ST_EVOL    = 4'd9,
    ST_BOND    = 4'd10,
    ST_MOOD    = 4'd11,
    ST_EMOTE   = 4'd12,
    ST_NONCE   = 4'd13
  } status_t;

  typedef struct packed {
    logic [23:0] header_word;
    logic [7:0]  offer_code;
    logic [7:0]  reply_code;
    logic [4:0]  max_appearance;
    logic [2:0]  max_evolution;
    logic [7:0]  max_bond;
    logic [3:0]  max_mood;
    logic [3:0]  max_emote;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  packet_type;
    logic [15:0] uid;
    logic [31:0] pack_id;
    logic [4:0]  appearance;
    logic [2:0]  evolution;
    logic [7:0]  bond;
    logic [3:0]  mood;
    logic [3:0]  emote;
    logic [31:0] nonce;
  } result_t;

  // Byte i of the frame sits in element i.
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first: a fixed XOR network.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/cfd_cell.sv
// One byte cell of the frame chain: loads from its neighbor (the first cell from the input) when the chain shifts.
module cfd_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: hdl/cfd_checker.sv
// Frame checks in priority order and extraction of the result fields.
module cfd_checker (
  input  cfd_pkg::frame_t  frame,
  input  logic [15:0]      crc,
  input  logic             length_ok,
  input  cfd_pkg::cfg_t    cfg,
  output cfd_pkg::result_t result
);
  import cfd_pkg::*;

  result_t fields;
  status_t status;
  logic    type_ok;

  assign type_ok = (frame[3] == cfg.offer_code) || (frame[3] == cfg.reply_code);

  always_comb begin
    fields             = '0;
    fields.packet_type = frame[3];
    fields.uid         = {frame[5], frame[4]};
    fields.pack_id     = {frame[9], frame[8], frame[7], frame[6]};
    fields.appearance  = frame[10][4:0];
    fields.evolution   = frame[10][7:5];
    fields.bond        = frame[11];
    fields.mood        = frame[12][3:0];
    fields.emote       = frame[12][7:4];
    fields.nonce       = {frame[16], frame[15], frame[14], frame[13]};

    if (!length_ok) begin
      status = ST_LENGTH;
    end else if (frame[0] != cfg.header_word[7:0] || frame[1] != cfg.header_word[15:8]) begin
      status = ST_HEADER;
    end else if (frame[2] != cfg.header_word[23:16]) begin
      status = ST_VERSION;
    end else if (!type_ok) begin
      status = ST_TYPE;
    end else if ({frame[18], frame[17]} != crc) begin
      status = ST_CRC;
    end else if (fields.uid == '0) begin
      status = ST_UID;
    end else if (fields.pack_id == '0) begin
      status = ST_PACK;
    end else if (fields.appearance > cfg.max_appearance) begin
      status = ST_APPEAR;
    end else if (fields.evolution > cfg.max_evolution) begin
      status = ST_EVOL;
    end else if (fields.bond > cfg.max_bond) begin
      status = ST_BOND;
    end else if (fields.mood > cfg.max_mood) begin
      status = ST_MOOD;
    end else if (fields.emote > cfg.max_emote) begin
      status = ST_EMOTE;
    end else if (fields.nonce == '0) begin
      status = ST_NONCE;
    end else begin
      status = ST_OK;
    end

    if (status == ST_OK) begin
      result = fields;
    end else begin
      result = '0;
    end
    result.status = status;
  end

endmodule

FILE: hdl/crc_checked_frame_decoder.sv
// Top level of the fixed-frame decoder with CRC-16/CCITT-FALSE check.
//
// Usage: frame bytes enter on the slave stream, one beat per byte, with
// s_tlast high on the final byte of a frame. A new beat is taken in every
// cycle while the output side keeps up. The final beat of a frame
// produces exactly one result beat on the master stream in the next cycle;
// other beats produce none. The result carries the status code in m_tuser
// and the decoded fields in m_tdata; on any error
// every field is zero. Frames that are not exactly 19 bytes long report a
// length error. Bytes are held in a chain of byte cells that shifts once per
// stored byte, and the CRC advances one byte per beat through a fixed XOR
// network, so the rate is set by nothing but the single output register.
// When the receiver stalls, the result waits in the output register and the
// input keeps taking beats until a second result would be needed; then
// s_tready drops until the pending result is taken. Reset clears the byte
// count, restarts the CRC, drops m_tvalid and loads the register defaults.
// Configuration writes go through cfg_we/cfg_index/cfg_data and must only be
// made while no frame is in flight.
module crc_checked_frame_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,  // [7:0] data_byte
  input  logic                                 s_tlast,  // last_byte
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata, lowest bit up: packet_type[7:0], uid[23:8], pack_id[55:24],
  // appearance[60:56], evolution[63:61], bond[71:64], mood[75:72],
  // emote[79:76], nonce[111:80]
  output logic [111:0]                         m_tdata,
  output logic [3:0]                           m_tuser,  // [3:0] status
  input  logic                                 cfg_we,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cfd_pkg::*;

  cfg_t                cfg;
  logic [COUNT_W-1:0]  byte_count;
  logic [15:0]         running_crc;
  logic [7:0]          chain [CHAIN_CELLS];
  logic                accept;
  logic                chain_shift;
  logic                length_ok;
  frame_t              frame;
  result_t             check_result;
  result_t             out_result;

  // Beats that end no frame never need the output register, so they are
  // always taken. The final beat of a frame waits until the output register
  // is free or being emptied.
  assign s_tready = !s_tlast || !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_word    <= '0;
      cfg.offer_code     <= 8'd1;
      cfg.reply_code     <= 8'd2;
      cfg.max_appearance <= 5'd31;
      cfg.max_evolution  <= 3'd7;
      cfg.max_bond       <= 8'd255;
      cfg.max_mood       <= 4'd15;
      cfg.max_emote      <= 4'd15;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HEADER_WORD:    cfg.header_word    <= cfg_data[23:0];
        CFG_OFFER_CODE:     cfg.offer_code     <= cfg_data[7:0];
        CFG_REPLY_CODE:     cfg.reply_code     <= cfg_data[7:0];
        CFG_MAX_APPEARANCE: cfg.max_appearance <= cfg_data[4:0];
        CFG_MAX_EVOLUTION:  cfg.max_evolution  <= cfg_data[2:0];
        CFG_MAX_BOND:       cfg.max_bond       <= cfg_data[7:0];
        CFG_MAX_MOOD:       cfg.max_mood       <= cfg_data[3:0];
        CFG_MAX_EMOTE:      cfg.max_emote      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Byte counter (saturating) and running CRC over the covered span.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= CRC_INIT;
    end else if (accept) begin
      if (s_tlast) begin
        byte_count  <= '0;
        running_crc <= CRC_INIT;
      end else begin
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + COUNT_W'(1);
        end
        if (byte_count < COUNT_W'(CRC_SPAN)) begin
          running_crc <= crc_byte(running_crc, s_tdata[7:0]);
        end
      end
    end
  end

  // The chain holds every byte but the final one, which is checked straight
  // from the input beat. Cell 0 takes the newest byte, so after the first
  // eighteen bytes of a frame cell k holds byte 17 - k.
  assign chain_shift = accept && (byte_count < COUNT_W'(CHAIN_CELLS));

  cfd_cell u_cell0 (
    .clk   (clk),
    .shift (chain_shift),
    .d     (s_tdata[7:0]),
    .q     (chain[0])
  );

  for (genvar k = 1; k < CHAIN_CELLS; k++) begin : g_cell
    cfd_cell u_cell (
      .clk   (clk),
      .shift (chain_shift),
      .d     (chain[k-1]),
      .q     (chain[k])
    );
  end

  always_comb begin
    for (int i = 0; i < CHAIN_CELLS; i++) begin
      frame[i] = chain[CHAIN_CELLS-1-i];
    end
    frame[FRAME_BYTES-1] = s_tdata[7:0];
  end

  // The final beat must be byte index FRAME_BYTES-1.
  assign length_ok = (byte_count == COUNT_W'(FRAME_BYTES - 1));

  cfd_checker u_checker (
    .frame     (frame),
    .crc       (running_crc),
    .length_ok (length_ok),
    .cfg       (cfg),
    .result    (check_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      out_result <= check_result;
    end
  end

  assign m_tuser = out_result.status;
  assign m_tdata = {out_result.nonce, out_result.emote, out_result.mood, out_result.bond,
                    out_result.evolution, out_result.appearance, out_result.pack_id,
                    out_result.uid, out_result.packet_type};

endmodule

FILE: test/frame_result_checker.sv
// Checker that tracks the decoder's registers, predicts each frame result and compares it.
`timescale 1ns / 1ps

module frame_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [111:0]                   m_tdata,
  input  logic [3:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                             mismatches,
  output int                             results_pending
);
  import cfd_pkg::*;

  localparam logic [15:0] CCITT_POLY = 16'h1021;
  localparam logic [15:0] CCITT_SEED = 16'hFFFF;
  localparam cfg_t REG_DEFAULTS = {24'h000000, 8'd1, 8'd2, 5'd31, 3'd7, 8'd255, 4'd15, 4'd15};

  cfg_t        regs;
  logic [4:0]  byte_count;
  logic [15:0] crc_acc;
  frame_t      frame_bytes;
  result_t     results_due[$];
  int          err_count = 0;

  assign mismatches = err_count;

  // Bit-serial CRC-16/CCITT-FALSE, one data bit per step, MSB first.
  function automatic logic [15:0] crc_after_byte(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Result of a finished frame: checks in priority order, fields only when all pass.
  function automatic result_t judge_frame(input frame_t f, input logic [4:0] n,
                                          input logic [15:0] c, input cfg_t r);
    result_t v;
    status_t st;
    v  = '0;
    st = ST_OK;
    if (n != FRAME_BYTES) begin
      st = ST_LENGTH;
    end else if (f[0] != r.header_word[7:0] || f[1] != r.header_word[15:8]) begin
      st = ST_HEADER;
    end else if (f[2] != r.header_word[23:16]) begin
      st = ST_VERSION;
    end else if (f[3] != r.offer_code && f[3] != r.reply_code) begin
      st = ST_TYPE;
    end else if ({f[18], f[17]} != c) begin
      st = ST_CRC;
    end else begin
      v.packet_type = f[3];
      v.uid         = {f[5], f[4]};
      v.pack_id     = {f[9], f[8], f[7], f[6]};
      v.appearance  = f[10][4:0];
      v.evolution   = f[10][7:5];
      v.bond        = f[11];
      v.mood        = f[12][3:0];
      v.emote       = f[12][7:4];
      v.nonce       = {f[16], f[15], f[14], f[13]};
      if (v.uid == 0) st = ST_UID;
      else if (v.pack_id == 0) st = ST_PACK;
      else if (v.appearance > r.max_appearance) st = ST_APPEAR;
      else if (v.evolution > r.max_evolution) st = ST_EVOL;
      else if (v.bond > r.max_bond) st = ST_BOND;
      else if (v.mood > r.max_mood) st = ST_MOOD;
      else if (v.emote > r.max_emote) st = ST_EMOTE;
      else if (v.nonce == 0) st = ST_NONCE;
      if (st != ST_OK) v = '0;
    end
    v.status = st;
    return v;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf({"status=%0d type=%02h uid=%04h pack=%08h appear=%0d evol=%0d",
                      " bond=%02h mood=%0d emote=%0d nonce=%08h"},
                     r.status, r.packet_type, r.uid, r.pack_id, r.appearance,
                     r.evolution, r.bond, r.mood, r.emote, r.nonce);
  endfunction

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t %s", $time, what);
      $display("  expected %s", describe(want));
      $display("  actual   %s", describe(got));
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      regs       = REG_DEFAULTS;
      byte_count = '0;
      crc_acc    = CCITT_SEED;
      results_due.delete();
    end else begin
      // A result leaving now was queued on an earlier beat, so check it first.
      if (m_tvalid && m_tready) begin
        seen.status      = status_t'(m_tuser);
        seen.packet_type = m_tdata[7:0];
        seen.uid         = m_tdata[23:8];
        seen.pack_id     = m_tdata[55:24];
        seen.appearance  = m_tdata[60:56];
        seen.evolution   = m_tdata[63:61];
        seen.bond        = m_tdata[71:64];
        seen.mood        = m_tdata[75:72];
        seen.emote       = m_tdata[79:76];
        seen.nonce       = m_tdata[111:80];
        if (results_due.size() == 0) begin
          note_mismatch("result beat with no frame pending", '0, seen);
        end else begin
          want = results_due.pop_front();
          if (seen.status !== want.status || seen.packet_type !== want.packet_type ||
              seen.uid !== want.uid || seen.pack_id !== want.pack_id ||
              seen.appearance !== want.appearance || seen.evolution !== want.evolution ||
              seen.bond !== want.bond || seen.mood !== want.mood ||
              seen.emote !== want.emote || seen.nonce !== want.nonce) begin
            note_mismatch("result beat differs from prediction", want, seen);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (byte_count < FRAME_BYTES) frame_bytes[byte_count] = s_tdata;
        if (byte_count < CRC_SPAN) crc_acc = crc_after_byte(crc_acc, s_tdata);
        if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
        if (s_tlast) begin
          results_due.push_back(judge_frame(frame_bytes, byte_count, crc_acc, regs));
          byte_count = '0;
          crc_acc    = CCITT_SEED;
        end
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_HEADER_WORD:    regs.header_word    = cfg_data[23:0];
          CFG_OFFER_CODE:     regs.offer_code     = cfg_data[7:0];
          CFG_REPLY_CODE:     regs.reply_code     = cfg_data[7:0];
          CFG_MAX_APPEARANCE: regs.max_appearance = cfg_data[4:0];
          CFG_MAX_EVOLUTION:  regs.max_evolution  = cfg_data[2:0];
          CFG_MAX_BOND:       regs.max_bond       = cfg_data[7:0];
          CFG_MAX_MOOD:       regs.max_mood       = cfg_data[3:0];
          CFG_MAX_EMOTE:      regs.max_emote      = cfg_data[3:0];
          default: ;
        endcase
      end
    end
    results_pending <= results_due.size();
  end

endmodule

FILE: test/tb_top.sv
// Top of the frame decoder testbench: clock, reset, frame stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_top;
  import cfd_pkg::*;

  // Generous bound: the slowest legal run stays far below this many cycles.
  localparam int unsigned RUN_LIMIT = 500000;
  // Bytes of random frames sent in each register phase.
  localparam int PHASE_BYTES = 200;
  localparam cfg_t REG_DEFAULTS = {24'h000000, 8'd1, 8'd2, 5'd31, 3'd7, 8'd255, 4'd15, 4'd15};
  // Mid-range limits, so that every field has both a legal and an illegal range.
  localparam cfg_t DIRECTED_CFG = {24'h01A55A, 8'h10, 8'h20, 5'd20, 3'd4, 8'd200, 4'd9, 4'd11};

  typedef enum int {
    K_GOOD, K_MAGIC, K_VERSION, K_TYPE, K_CRC, K_UID, K_PACK, K_APPEAR,
    K_EVOL, K_BOND, K_MOOD, K_EMOTE, K_NONCE, K_SHORT, K_LONG, K_NOISE
  } frame_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic [7:0]             s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire  [111:0]           m_tdata;
  wire  [3:0]             m_tuser;
  int                     mismatches;
  int                     results_owed;

  // Register values in force, as the stimulus needs them to build frames.
  cfg_t        live_cfg = REG_DEFAULTS;
  logic [7:0]  frame_q[$];
  int          bytes_sent = 0;
  int          burst_left = 0;
  int unsigned cycle_no = 0;
  int unsigned stall_style = 0;

  always #5 clk = ~clk;

  crc_checked_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_result_checker result_chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_pending (results_owed)
  );

  // The receiver switches among stall styles at random: always
  // ready, lightly or heavily random, a short periodic stall, or a long one
  // that keeps a result parked long enough to push back on the input side.
  // The same block bounds the run.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 300 == 0) stall_style <= $urandom_range(0, 4);
    case (stall_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= 1'($urandom_range(0, 1));
      3:       m_tready <= (cycle_no[3:0] < 4'd10);
      default: m_tready <= (cycle_no[5:0] < 6'd20);
    endcase
    if (cycle_no == RUN_LIMIT) begin
      $display("[crc_checked_frame_decoder] ERROR");
      $finish;
    end
  end

  // Random half the time, otherwise either end of the range with even odds.
  function automatic logic [31:0] pick(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Builds one frame in frame_q. Every frame starts out well formed under the
  // live registers, with a correct CRC; K_NOISE then randomizes every byte, and
  // other kinds break at most one thing so that the check it targets fails first.
  task automatic build_frame(input frame_kind_t kind);
    frame_t      f;
    logic [15:0] c;
    int          n;
    f[0] = live_cfg.header_word[7:0];
    f[1] = live_cfg.header_word[15:8];
    f[2] = live_cfg.header_word[23:16];
    f[3] = $urandom_range(0, 1) ? live_cfg.offer_code : live_cfg.reply_code;
    {f[5], f[4]} = 16'(pick(1, 32'h0000FFFF));
    {f[9], f[8], f[7], f[6]} = pick(1, 32'hFFFFFFFF);
    f[10][4:0] = 5'(pick(0, 32'(live_cfg.max_appearance)));
    f[10][7:5] = 3'(pick(0, 32'(live_cfg.max_evolution)));
    f[11] = 8'(pick(0, 32'(live_cfg.max_bond)));
    f[12][3:0] = 4'(pick(0, 32'(live_cfg.max_mood)));
    f[12][7:4] = 4'(pick(0, 32'(live_cfg.max_emote)));
    {f[16], f[15], f[14], f[13]} = pick(1, 32'hFFFFFFFF);
    case (kind)
      K_MAGIC:   f[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      K_VERSION: f[2] ^= 8'($urandom_range(1, 255));
      K_TYPE: begin
        do f[3] = 8'($urandom);
        while (f[3] == live_cfg.offer_code || f[3] == live_cfg.reply_code);
      end
      K_UID:  {f[5], f[4]} = '0;
      K_PACK: {f[9], f[8], f[7], f[6]} = '0;
      // An over-limit value exists only while the limit sits below the top.
      K_APPEAR: begin
        if (live_cfg.max_appearance != 5'd31)
          f[10][4:0] = 5'($urandom_range(31, live_cfg.max_appearance + 1));
      end
      K_EVOL: begin
        if (live_cfg.max_evolution != 3'd7)
          f[10][7:5] = 3'($urandom_range(7, live_cfg.max_evolution + 1));
      end
      K_BOND: begin
        if (live_cfg.max_bond != 8'd255)
          f[11] = 8'($urandom_range(255, live_cfg.max_bond + 1));
      end
      K_MOOD: begin
        if (live_cfg.max_mood != 4'd15)
          f[12][3:0] = 4'($urandom_range(15, live_cfg.max_mood + 1));
      end
      K_EMOTE: begin
        if (live_cfg.max_emote != 4'd15)
          f[12][7:4] = 4'($urandom_range(15, live_cfg.max_emote + 1));
      end
      K_NONCE: {f[16], f[15], f[14], f[13]} = '0;
      default: ;
    endcase
    c = 16'hFFFF;
    for (int i = 0; i < CRC_SPAN; i++) c = crc_byte(c, f[i]);
    {f[18], f[17]} = c;
    if (kind == K_CRC) {f[18], f[17]} = c ^ 16'($urandom_range(1, 65535));
    if (kind == K_NOISE) begin
      for (int i = 0; i < FRAME_BYTES; i++) f[i] = 8'($urandom);
    end
    // A short frame is a cut-off good one; a long one runs on past the end,
    // often far enough to saturate the decoder's byte count.
    n = (kind == K_SHORT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    frame_q.delete();
    for (int i = 0; i < n; i++) frame_q.push_back(f[i]);
    if (kind == K_LONG) begin
      n = $urandom_range(1, 26);
      for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
    end
  endtask

  // Offers one beat and returns at the edge that accepts it. The sender
  // works in bursts; a gap is opened only between bursts, and long bursts
  // give stretches with no idling at all.
  task automatic push_beat(input logic [7:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    build_frame(kind);
    foreach (frame_q[i]) push_beat(frame_q[i], i == frame_q.size() - 1);
    bytes_sent += frame_q.size();
  endtask

  // Stops the input and waits for the last result, then idles on so that
  // the decoder is certainly idle before any register is touched.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes all eight registers on back-to-back cycles; the enable is dropped
  // only once, after the final write.
  task automatic load_settings(input cfg_t c);
    live_cfg = c;
    put_reg(CFG_HEADER_WORD, c.header_word);
    put_reg(CFG_OFFER_CODE, c.offer_code);
    put_reg(CFG_REPLY_CODE, c.reply_code);
    put_reg(CFG_MAX_APPEARANCE, c.max_appearance);
    put_reg(CFG_MAX_EVOLUTION, c.max_evolution);
    put_reg(CFG_MAX_BOND, c.max_bond);
    put_reg(CFG_MAX_MOOD, c.max_mood);
    put_reg(CFG_MAX_EMOTE, c.max_emote);
    cfg_we <= 1'b0;
  endtask

  // Register settings of the random phases: everything at the top with equal
  // type codes, every limit and the header word at the bottom, then fully random settings.
  function automatic cfg_t phase_settings(input int p);
    cfg_t c;
    case (p)
      0: c = {24'hFFFFFF, 8'hFF, 8'hFF, 5'd31, 3'd7, 8'd255, 4'd15, 4'd15};
      1: c = {24'h000000, 8'h00, 8'hFF, 5'd0, 3'd0, 8'd0, 4'd0, 4'd0};
      default: begin
        c.header_word    = 24'($urandom);
        c.offer_code     = 8'($urandom);
        c.reply_code     = 8'($urandom);
        c.max_appearance = 5'($urandom);
        c.max_evolution  = 3'($urandom);
        c.max_bond       = 8'($urandom);
        c.max_mood       = 4'($urandom);
        c.max_emote      = 4'($urandom);
      end
    endcase
    return c;
  endfunction

  // Most random frames are well formed so that the field checks are reached;
  // the rest spread over every way a frame can go wrong.
  function automatic frame_kind_t random_kind();
    if ($urandom_range(0, 99) < 60) return K_GOOD;
    return frame_kind_t'($urandom_range(K_MAGIC, K_NOISE));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One good frame under the reset values of the registers.
    send_frame(K_GOOD);
    settle();

    // Directed part: one frame of every kind.
    load_settings(DIRECTED_CFG);
    for (int k = K_GOOD; k <= K_NOISE; k++) send_frame(frame_kind_t'(k));
    settle();

    for (int p = 0; p < 5; p++) begin
      load_settings(phase_settings(p));
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_frame(random_kind());
      settle();
    end

    if (mismatches == 0) begin
      $display("[crc_checked_frame_decoder] OK");
    end else begin
      $display("[crc_checked_frame_decoder] ERROR");
    end
    $finish;
  end

endmodule
